### hdl/smf_tep_pkg.sv
// Shared types, codes and the data-byte table for the SMF track event parser.
// Used by smf_track_event_parser and its port checker; no dependencies.

package smf_tep_pkg;

    localparam logic [2:0] PH_DELTA   = 3'd0;
    localparam logic [2:0] PH_STATUS  = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;

    // Message length including the status byte, indexed by the channel status nibble.
    localparam logic [1:0] CHAN_LEN [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1};

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] delta_time;
        logic [7:0]  status;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        running_status_used;
    } result_t;

    function automatic logic [1:0] data_needed(input logic [7:0] s);
        if (s < ST_SYSEX)
        begin
            return CHAN_LEN[s[6:4]] - 2'd1;
        end
        else if (s == ST_SONG_POS)
        begin
            return 2'd2;
        end
        else if (s == ST_SONG_SEL)
        begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

endpackage

### hdl/smf_track_event_parser.sv
// Standard MIDI file track event parser: one track byte in, at most one event item out.
// Depends on smf_tep_pkg for phase codes, event kinds, the result type and data_needed.
//
//  Channel   Dir  tdata                     tuser            tlast
//  s_axis    in   [7:0] track_byte          [0] track_start  -
//  m_axis    out  see port comment          [1:0] event_kind payload_last
//
// While s_axis_tready is high, one byte is taken per cycle and updates the parse state.
// Results are registered in the output register, or in the skid register if it is held.
// The output register plus a skid register let one result wait while the next byte is taken;
// s_axis_tready drops only when both are full.
// Reset clears the parse state and running status and empties both output registers.

module smf_track_event_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] track_byte
    input  logic         s_axis_tuser,  // [0] track_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] delta_time, [39:32] status, [47:40] data_first, [55:48] data_second,
    // [87:56] payload_length, [95:88] payload_byte, [96] running_status_used, [103:97] zero
    output logic [103:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] event_kind
    output logic         m_axis_tlast
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] delta_reg, delta_next;
    logic [7:0]  rs_reg, rs_next;
    logic [1:0]  dbl_reg, dbl_next;
    logic [7:0]  hf_reg, hf_next;
    logic [7:0]  hs_reg, hs_next;
    logic [31:0] la_reg, la_next;
    logic [31:0] pr_reg, pr_next;
    logic        swr_reg, swr_next;

    logic                 accept;
    logic                 res_valid;
    smf_tep_pkg::result_t res;
    logic                 do_data;
    logic                 do_length;
    logic                 do_payload;
    logic                 emit;
    logic [7:0]           b;

    smf_tep_pkg::result_t main_reg;
    smf_tep_pkg::result_t skid_reg;
    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    logic                 pop;
    logic                 push;

    assign b      = s_axis_tdata;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        phase_next = phase_reg;
        delta_next = delta_reg;
        rs_next    = rs_reg;
        dbl_next   = dbl_reg;
        hf_next    = hf_reg;
        hs_next    = hs_reg;
        la_next    = la_reg;
        pr_next    = pr_reg;
        swr_next   = swr_reg;
        res_valid  = 1'b0;
        res        = '0;
        do_data    = 1'b0;
        do_length  = 1'b0;
        do_payload = 1'b0;
        emit       = 1'b0;

        if (s_axis_tuser)
        begin
            phase_next = smf_tep_pkg::PH_DELTA;
            delta_next = '0;
            rs_next    = '0;
            dbl_next   = '0;
            hf_next    = '0;
            hs_next    = '0;
            la_next    = '0;
            pr_next    = '0;
            swr_next   = 1'b0;
        end

        unique case (phase_next)
            smf_tep_pkg::PH_STATUS:
            begin
                if (b[7])
                begin
                    rs_next = b;
                end
                swr_next = !b[7];
                hf_next  = '0;
                hs_next  = '0;
                la_next  = '0;
                pr_next  = '0;
                if (rs_next == smf_tep_pkg::ST_SYSEX || rs_next == smf_tep_pkg::ST_SYSEX_ESC)
                begin
                    phase_next = smf_tep_pkg::PH_LENGTH;
                    do_length  = !b[7];
                end
                else if (rs_next == smf_tep_pkg::ST_META)
                begin
                    phase_next = smf_tep_pkg::PH_TYPE;
                    if (!b[7])
                    begin
                        hf_next    = b;
                        phase_next = smf_tep_pkg::PH_LENGTH;
                    end
                end
                else
                begin
                    dbl_next = smf_tep_pkg::data_needed(rs_next);
                    if (dbl_next == 2'd0)
                    begin
                        res_valid              = 1'b1;
                        res.event_kind         = smf_tep_pkg::KIND_SHORT;
                        res.delta_time          = delta_next;
                        res.status              = rs_next;
                        res.data_first          = hf_next;
                        res.data_second         = hs_next;
                        res.running_status_used = swr_next;
                        phase_next = smf_tep_pkg::PH_DELTA;
                        delta_next = '0;
                        if (!b[7])
                        begin
                            // A data byte after a data-less system status opens the next delta.
                            delta_next = {25'd0, b[6:0]};
                            phase_next = smf_tep_pkg::PH_STATUS;
                        end
                    end
                    else
                    begin
                        phase_next = smf_tep_pkg::PH_DATA;
                        do_data    = !b[7];
                    end
                end
            end
            smf_tep_pkg::PH_DATA:
            begin
                do_data = 1'b1;
            end
            smf_tep_pkg::PH_TYPE:
            begin
                hf_next    = b;
                la_next    = '0;
                phase_next = smf_tep_pkg::PH_LENGTH;
            end
            smf_tep_pkg::PH_LENGTH:
            begin
                do_length = 1'b1;
            end
            smf_tep_pkg::PH_PAYLOAD:
            begin
                do_payload = 1'b1;
            end
            default:
            begin
                delta_next = {delta_next[24:0], b[6:0]};
                phase_next = b[7] ? smf_tep_pkg::PH_DELTA : smf_tep_pkg::PH_STATUS;
            end
        endcase

        if (do_data)
        begin
            if (dbl_next == 2'd0)
            begin
                emit = 1'b1;
            end
            else
            begin
                if (smf_tep_pkg::data_needed(rs_next) == 2'd2 && dbl_next == 2'd1)
                begin
                    hs_next = b;
                end
                else
                begin
                    hf_next = b;
                end
                dbl_next = dbl_next - 2'd1;
                emit     = (dbl_next == 2'd0);
            end
            if (emit)
            begin
                res_valid               = 1'b1;
                res.event_kind          = smf_tep_pkg::KIND_SHORT;
                res.delta_time          = delta_next;
                res.status              = rs_next;
                res.data_first          = hf_next;
                res.data_second         = hs_next;
                res.running_status_used = swr_next;
                phase_next = smf_tep_pkg::PH_DELTA;
                delta_next = '0;
                dbl_next   = '0;
            end
        end

        if (do_length)
        begin
            la_next = {la_next[24:0], b[6:0]};
            if (!b[7])
            begin
                pr_next                 = la_next;
                res_valid               = 1'b1;
                res.event_kind          = smf_tep_pkg::KIND_HEADER;
                res.delta_time          = delta_next;
                res.status              = rs_next;
                res.data_first          = hf_next;
                res.payload_length      = la_next;
                res.running_status_used = swr_next;
                if (la_next == 32'd0)
                begin
                    phase_next = smf_tep_pkg::PH_DELTA;
                    delta_next = '0;
                    dbl_next   = '0;
                end
                else
                begin
                    phase_next = smf_tep_pkg::PH_PAYLOAD;
                end
            end
        end

        if (do_payload)
        begin
            if (pr_next != 32'd0)
            begin
                pr_next = pr_next - 32'd1;
            end
            res_valid               = 1'b1;
            res.event_kind          = smf_tep_pkg::KIND_PAYLOAD;
            res.delta_time          = delta_next;
            res.status              = rs_next;
            res.data_first          = hf_next;
            res.payload_length      = la_next;
            res.payload_byte        = b;
            res.payload_last        = (pr_next == 32'd0);
            res.running_status_used = swr_next;
            if (pr_next == 32'd0)
            begin
                phase_next = smf_tep_pkg::PH_DELTA;
                delta_next = '0;
                dbl_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= smf_tep_pkg::PH_DELTA;
            delta_reg <= '0;
            rs_reg    <= '0;
            dbl_reg   <= '0;
            hf_reg    <= '0;
            hs_reg    <= '0;
            la_reg    <= '0;
            pr_reg    <= '0;
            swr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            delta_reg <= delta_next;
            rs_reg    <= rs_next;
            dbl_reg   <= dbl_next;
            hf_reg    <= hf_next;
            hs_reg    <= hs_next;
            la_reg    <= la_next;
            pr_reg    <= pr_next;
            swr_reg   <= swr_next;
        end
    end

    assign pop           = main_valid_reg && m_axis_tready;
    assign push          = accept && res_valid;
    assign s_axis_tready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                main_reg <= res;
            end
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tuser  = main_reg.event_kind;
    assign m_axis_tlast  = main_reg.payload_last;
    assign m_axis_tdata  = {7'd0, main_reg.running_status_used, main_reg.payload_byte,
                            main_reg.payload_length, main_reg.data_second,
                            main_reg.data_first, main_reg.status, main_reg.delta_time};

endmodule

### hdl/smf_tep_checker.sv
// Port-level checker for smf_track_event_parser, attached by the bind below.
// Depends on smf_tep_pkg for event kind codes.

module smf_tep_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Stalled output item changed.");

    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with no output item waiting.");

    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == smf_tep_pkg::KIND_PAYLOAD)
        else $error("Last mark on an item that is not a payload byte.");

    a_short_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == smf_tep_pkg::KIND_SHORT
            |-> m_axis_tdata[95:56] == 40'd0)
        else $error("Short event carries payload fields.");

    a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != smf_tep_pkg::KIND_SHORT
            |-> m_axis_tdata[55:48] == 8'd0 && m_axis_tdata[103:97] == 7'd0
                && m_axis_tuser != 2'd3)
        else $error("Header or payload item with bad second data byte, padding or kind.");

endmodule

bind smf_track_event_parser smf_tep_checker u_smf_tep_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for smf_track_event_parser: directed and random track bytes.
// A scoreboard class predicts each event item; uses smf_tep_pkg for codes and result_t.

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BYTES = 500;
    localparam int OPENING_LEN = 37;

    localparam logic [8:0] OPENING [OPENING_LEN] = '{
        9'h100, 9'h012, 9'h034,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0E5, 9'h07F, 9'h000,
        9'h000, 9'h0F2, 9'h001, 9'h07F,
        9'h000, 9'h0F3, 9'h080,
        9'h000, 9'h0F8, 9'h005, 9'h0FF, 9'h003, 9'h080, 9'h001, 9'h0AA,
        9'h000, 9'h002, 9'h000,
        9'h000, 9'h0F0, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h011
    };

    class event_scoreboard;
        smf_tep_pkg::result_t pending_events[$];
        int mismatches;
        logic [2:0] phase;
        logic [31:0] delta_acc;
        logic [7:0] run_status;
        logic [1:0] bytes_left;
        logic [7:0] first_b;
        logic [7:0] second_b;
        logic [31:0] len_acc;
        logic [31:0] pay_left;
        logic from_running;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase = smf_tep_pkg::PH_DELTA;
            delta_acc = '0;
            run_status = '0;
            bytes_left = '0;
            first_b = '0;
            second_b = '0;
            len_acc = '0;
            pay_left = '0;
            from_running = 1'b0;
        endfunction

        function logic [1:0] data_count(input logic [7:0] s);
            if (s < smf_tep_pkg::ST_SYSEX)
            begin
                case (s[6:4])
                    3'd4, 3'd5: return 2'd1;
                    3'd7: return 2'd0;
                    default: return 2'd2;
                endcase
            end
            if (s == smf_tep_pkg::ST_SONG_POS)
            begin
                return 2'd2;
            end
            if (s == smf_tep_pkg::ST_SONG_SEL)
            begin
                return 2'd1;
            end
            return 2'd0;
        endfunction

        function void push_event(input logic [1:0] kind, input logic [31:0] plen,
                                 input logic [7:0] second, input logic [7:0] pbyte,
                                 input logic last_flag);
            smf_tep_pkg::result_t r;
            r.event_kind = kind;
            r.delta_time = delta_acc;
            r.status = run_status;
            r.data_first = first_b;
            r.data_second = second;
            r.payload_length = plen;
            r.payload_byte = pbyte;
            r.payload_last = last_flag;
            r.running_status_used = from_running;
            pending_events.push_back(r);
        endfunction

        function void start_delta();
            phase = smf_tep_pkg::PH_DELTA;
            delta_acc = '0;
            bytes_left = '0;
        endfunction

        function void take_delta(input logic [7:0] b);
            delta_acc = (delta_acc << 7) + {25'd0, b[6:0]};
            phase = b[7] ? smf_tep_pkg::PH_DELTA : smf_tep_pkg::PH_STATUS;
        endfunction

        function void emit_short();
            push_event(smf_tep_pkg::KIND_SHORT, 32'd0, second_b, 8'd0, 1'b0);
            start_delta();
        endfunction

        function void take_data(input logic [7:0] b);
            if (bytes_left == 2'd0)
            begin
                emit_short();
                return;
            end
            if (data_count(run_status) == 2'd2 && bytes_left == 2'd1)
                second_b = b;
            else
                first_b = b;
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0)
                emit_short();
        endfunction

        function void take_length(input logic [7:0] b);
            len_acc = (len_acc << 7) + {25'd0, b[6:0]};
            if (b[7])
                return;
            pay_left = len_acc;
            push_event(smf_tep_pkg::KIND_HEADER, len_acc, 8'd0, 8'd0, 1'b0);
            if (pay_left == 32'd0)
                start_delta();
            else
                phase = smf_tep_pkg::PH_PAYLOAD;
        endfunction

        function void take_payload(input logic [7:0] b);
            logic last_flag;
            if (pay_left != 32'd0)
                pay_left = pay_left - 32'd1;
            last_flag = (pay_left == 32'd0);
            push_event(smf_tep_pkg::KIND_PAYLOAD, len_acc, 8'd0, b, last_flag);
            if (last_flag)
                start_delta();
        endfunction

        function void take_status(input logic [7:0] b);
            logic run;
            logic [7:0] s;
            run = !b[7];
            if (!run)
                run_status = b;
            s = run_status;
            from_running = run;
            first_b = '0;
            second_b = '0;
            len_acc = '0;
            pay_left = '0;
            if (s == smf_tep_pkg::ST_SYSEX || s == smf_tep_pkg::ST_SYSEX_ESC)
            begin
                phase = smf_tep_pkg::PH_LENGTH;
                if (run)
                    take_length(b);
                return;
            end
            if (s == smf_tep_pkg::ST_META)
            begin
                phase = smf_tep_pkg::PH_TYPE;
                if (run)
                begin
                    first_b = b;
                    phase = smf_tep_pkg::PH_LENGTH;
                end
                return;
            end
            bytes_left = data_count(s);
            if (bytes_left == 2'd0)
            begin
                emit_short();
                if (run)
                    take_delta(b);
                return;
            end
            phase = smf_tep_pkg::PH_DATA;
            if (run)
                take_data(b);
        endfunction

        function void note_byte(input logic [7:0] b, input logic track_start);
            if (track_start)
                clear_state();
            case (phase)
                smf_tep_pkg::PH_STATUS: take_status(b);
                smf_tep_pkg::PH_DATA: take_data(b);
                smf_tep_pkg::PH_TYPE:
                begin
                    first_b = b;
                    len_acc = '0;
                    phase = smf_tep_pkg::PH_LENGTH;
                end
                smf_tep_pkg::PH_LENGTH: take_length(b);
                smf_tep_pkg::PH_PAYLOAD: take_payload(b);
                default:
                begin
                    phase = smf_tep_pkg::PH_DELTA;
                    take_delta(b);
                end
            endcase
        endfunction

        function string show(input smf_tep_pkg::result_t r);
            return $sformatf({"kind=%0d delta=%h status=%h first=%h second=%h",
                              " len=%h byte=%h last=%b run=%b"},
                             r.event_kind, r.delta_time, r.status, r.data_first, r.data_second,
                             r.payload_length, r.payload_byte, r.payload_last,
                             r.running_status_used);
        endfunction

        function void check_event(input smf_tep_pkg::result_t got);
            smf_tep_pkg::result_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event item: %s", show(got));
                return;
            end
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind || got.delta_time !== want.delta_time
                || got.status !== want.status || got.data_first !== want.data_first
                || got.data_second !== want.data_second
                || got.payload_length !== want.payload_length
                || got.payload_byte !== want.payload_byte
                || got.payload_last !== want.payload_last
                || got.running_status_used !== want.running_status_used)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("event mismatch, expected: %s", show(want));
                    $display("event mismatch, actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    event_scoreboard sb = new();
    int bytes_sent = 0;
    logic [7:0] gen_running = 8'h00;

    smf_track_event_parser i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit quiet_stretch();
        return bytes_sent >= 200 && bytes_sent < 330;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_stretch() || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin : event_monitor
        smf_tep_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.event_kind = m_axis_tuser;
            got.delta_time = m_axis_tdata[31:0];
            got.status = m_axis_tdata[39:32];
            got.data_first = m_axis_tdata[47:40];
            got.data_second = m_axis_tdata[55:48];
            got.payload_length = m_axis_tdata[87:56];
            got.payload_byte = m_axis_tdata[95:88];
            got.running_status_used = m_axis_tdata[96];
            got.payload_last = m_axis_tlast;
            sb.check_event(got);
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic track_start);
        while (!quiet_stretch() && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= track_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b, track_start);
        bytes_sent++;
    endtask

    task automatic send_varlen(input int nbytes, input logic track_start);
        logic [6:0] low;
        for (int i = 0; i < nbytes; i++)
        begin
            low = 7'($urandom);
            send_byte({i != nbytes - 1, low}, track_start && i == 0);
        end
    endtask

    task automatic send_payload(input bit run);
        int plen;
        plen = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        if (run)
            send_byte(plen[7:0], 1'b0);
        else
        begin
            if ($urandom_range(3) == 0)
                send_byte(8'h80, 1'b0);
            send_byte(plen[7:0], 1'b0);
        end
        for (int i = 0; i < plen; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    function automatic logic [7:0] pick_status();
        int r;
        int v;
        r = $urandom_range(99);
        v = $urandom_range(0, 10);
        if (r < 50)
            return 8'($urandom_range(8'h80, 8'hEF));
        if (r < 62)
            return r[0] ? smf_tep_pkg::ST_SYSEX : smf_tep_pkg::ST_SYSEX_ESC;
        if (r < 78)
            return smf_tep_pkg::ST_META;
        if (r < 84)
            return smf_tep_pkg::ST_SONG_POS;
        if (r < 89)
            return smf_tep_pkg::ST_SONG_SEL;
        case (v)
            0: return 8'hF1;
            1: return 8'hF4;
            2: return 8'hF5;
            3: return 8'hF6;
            default: return 8'hF8 + 8'(v - 4);
        endcase
    endfunction

    task automatic send_event(input logic track_start);
        int r;
        int n;
        bit run;
        logic [7:0] s;
        logic [6:0] low;
        r = $urandom_range(99);
        n = (r < 60) ? 1 : (r < 85) ? 2 : (r < 95) ? $urandom_range(3, 4) : 5;
        send_varlen(n, track_start);
        if (track_start)
            gen_running = 8'h00;
        run = (gen_running < smf_tep_pkg::ST_SYSEX || gen_running == smf_tep_pkg::ST_SYSEX
               || gen_running == smf_tep_pkg::ST_SYSEX_ESC
               || gen_running == smf_tep_pkg::ST_META
               || gen_running == smf_tep_pkg::ST_SONG_POS
               || gen_running == smf_tep_pkg::ST_SONG_SEL)
              && $urandom_range(99) < 30;
        if (run)
            s = gen_running;
        else
        begin
            s = pick_status();
            send_byte(s, 1'b0);
            gen_running = s;
        end
        if (s == smf_tep_pkg::ST_SYSEX || s == smf_tep_pkg::ST_SYSEX_ESC)
            send_payload(run);
        else if (s == smf_tep_pkg::ST_META)
        begin
            low = 7'($urandom);
            send_byte(run ? {1'b0, low} : 8'($urandom_range(255)), 1'b0);
            send_payload(1'b0);
        end
        else
        begin
            n = int'(sb.data_count(s));
            for (int i = 0; i < n; i++)
            begin
                low = 7'($urandom);
                if ((i == 0 && run) || $urandom_range(9) != 0)
                    send_byte({1'b0, low}, 1'b0);
                else
                    send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial
    begin : stimulus
        int r;
        bit resync;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < OPENING_LEN; i++)
            send_byte(OPENING[i][7:0], OPENING[i][8]);
        resync = 1'b1;
        while (bytes_sent < OPENING_LEN + RANDOM_BYTES)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
                resync = 1'b1;
            end
            else
            begin
                send_event(resync || r >= 95);
                resync = 1'b0;
            end
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
